@@ design/bpat_pkg.sv @@
package bpat_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // Signal class codes kept per slot. Unknown is never sent on the output.
  typedef logic [2:0] code_t;
  localparam code_t CODE_LOST    = 3'd0;
  localparam code_t CODE_WEAK    = 3'd1;
  localparam code_t CODE_MEDIUM  = 3'd2;
  localparam code_t CODE_STRONG  = 3'd3;
  localparam code_t CODE_UNKNOWN = 3'd4;

  localparam logic CMD_HEARD   = 1'b0;
  localparam logic CMD_REFRESH = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] source_addr;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        has_room;
    logic [31:0] room_addr;
    logic [1:0]  strength;
    logic        any_update;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic addr_we;
    logic time_we;
    logic rep_we;
    logic set_valid;
    logic clr_valid;
  } store_ctl_t;

  typedef struct packed {
    logic  lost;
    logic  changed;
    code_t cls;
    logic  addr_match;
  } age_res_t;

endpackage

@@ design/bpat_age_unit.sv @@
module bpat_age_unit import bpat_pkg::*; (
  input  logic [7:0]  interval,
  input  logic [31:0] now,
  input  logic [31:0] heard_time,
  input  code_t       reported,
  input  logic [31:0] slot_addr,
  input  logic [31:0] key_addr,
  output age_res_t    res
);

  logic [10:0] t2;
  logic [10:0] t4;
  logic [10:0] t6;
  logic [31:0] diff;
  logic        neg;
  logic        over6;
  code_t       cls;

  // Thresholds are small multiples of the interval, built from shifts and one add.
  assign t2    = {2'b00, interval, 1'b0};
  assign t4    = {1'b0, interval, 2'b00};
  assign t6    = t2 + t4;
  assign diff  = now - heard_time;
  assign neg   = diff[31];
  assign over6 = !neg && (diff > {21'd0, t6});

  always_comb begin
    if (neg || diff <= {21'd0, t2}) begin
      cls = CODE_STRONG;
    end else if (diff <= {21'd0, t4}) begin
      cls = CODE_MEDIUM;
    end else begin
      cls = CODE_WEAK;
    end
  end

  assign res.lost       = over6;
  assign res.cls        = over6 ? CODE_LOST : cls;
  assign res.changed    = !over6 && (cls != reported);
  assign res.addr_match = (slot_addr == key_addr);

endmodule

@@ design/bpat_store.sv @@
module bpat_store import bpat_pkg::*; #(
  parameter int ROOMS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(ROOMS)-1:0] rd_idx,
  output logic [31:0]              rd_addr,
  output logic [31:0]              rd_time,
  output code_t                    rd_rep,
  input  store_ctl_t               ctl,
  input  logic [$clog2(ROOMS)-1:0] wr_idx,
  input  logic [31:0]              wr_addr,
  input  logic [31:0]              wr_time,
  input  code_t                    wr_rep,
  output logic [ROOMS-1:0]         valid
);

  logic [31:0] addr_mem [ROOMS];
  logic [31:0] time_mem [ROOMS];
  code_t       rep_mem  [ROOMS];
  logic [31:0] rd_addr_r;
  logic [31:0] rd_time_r;
  code_t       rd_rep_r;
  logic [ROOMS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_r <= addr_mem[rd_idx];
      rd_time_r <= time_mem[rd_idx];
      rd_rep_r  <= rep_mem[rd_idx];
    end
    if (ctl.addr_we) begin
      addr_mem[wr_idx] <= wr_addr;
    end
    if (ctl.time_we) begin
      time_mem[wr_idx] <= wr_time;
    end
    if (ctl.rep_we) begin
      rep_mem[wr_idx] <= wr_rep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.set_valid) begin
      valid_r[wr_idx] <= 1'b1;
    end else if (ctl.clr_valid) begin
      valid_r[wr_idx] <= 1'b0;
    end
  end

  assign rd_addr = rd_addr_r;
  assign rd_time = rd_time_r;
  assign rd_rep  = rd_rep_r;
  assign valid   = valid_r;

endmodule

@@ design/beacon_presence_aging_table_core.sv @@
// Beacon presence aging table.
// The input channel (in_valid, in_ready, in_item) takes one item at a time.
// A heard item looks up its source address and stores the time for it, taking
// the lowest free slot for a new address; with the table full it is dropped
// and its single result shows accepted low. A refresh item ages every valid
// slot in slot order and sends one result per room whose class changed, the
// final one marked last with any_update set, or one empty last result.
// Each item walks all ROOMS slots through one memory read port and one shared
// compare unit, and a new item is taken only after the final result of the
// previous one is registered.
// in_ready is high only while the block is idle.
// Results leave through a one-entry output register (out_valid, out_ready,
// out_item). If the receiver stalls while a refresh has more rooms to report,
// the slot walk pauses until the register frees up; nothing is lost.
// The configuration port (cfg_valid, cfg_ready, cfg_beacon_interval) is always
// ready and sets the beacon interval, 1 after reset.
// Reset is synchronous and active low; it empties the table at once.
module beacon_presence_aging_table_core import bpat_pkg::*; #(
  parameter int ROOMS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_beacon_interval
);

  localparam int AW = $clog2(ROOMS);
  localparam int CW = $clog2(ROOMS + 1);

  state_t         state_r, state_nxt;
  in_item_t       item_r, item_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic           pend_r, pend_nxt;
  logic [AW-1:0]  pidx_r, pidx_nxt;
  logic           hit_r, hit_nxt;
  logic [AW-1:0]  hit_idx_r, hit_idx_nxt;
  logic           free_r, free_nxt;
  logic [AW-1:0]  free_idx_r, free_idx_nxt;
  logic           held_v_r, held_v_nxt;
  out_item_t      held_r, held_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_r, out_nxt;
  logic [7:0]     interval_r;

  logic           rd_en;
  logic [31:0]    rd_addr;
  logic [31:0]    rd_time;
  code_t          rd_rep;
  store_ctl_t     ctl;
  logic [AW-1:0]  wr_idx;
  code_t          wr_rep;
  logic [ROOMS-1:0] valid;
  age_res_t       res;

  logic slot_v;
  logic out_free;
  logic refresh;
  logic emit;
  logic stall;
  logic issue;
  logic eval;
  logic out_load;

  bpat_store #(.ROOMS(ROOMS)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_idx  (idx_r[AW-1:0]),
    .rd_addr (rd_addr),
    .rd_time (rd_time),
    .rd_rep  (rd_rep),
    .ctl     (ctl),
    .wr_idx  (wr_idx),
    .wr_addr (item_r.source_addr),
    .wr_time (item_r.now),
    .wr_rep  (wr_rep),
    .valid   (valid)
  );

  bpat_age_unit u_age (
    .interval   (interval_r),
    .now        (item_r.now),
    .heard_time (rd_time),
    .reported   (rd_rep),
    .slot_addr  (rd_addr),
    .key_addr   (item_r.source_addr),
    .res        (res)
  );

  // The slot being evaluated is the one last read, whose index is held in pidx_r.
  assign slot_v   = valid[pidx_r];
  assign out_free = !out_valid_r || out_ready;
  assign refresh  = (item_r.cmd == CMD_REFRESH);
  assign emit     = (state_r == ST_SCAN) && pend_r && refresh && slot_v
                    && (res.lost || res.changed);
  // A new room report needs the held report moved out first.
  assign stall    = emit && held_v_r && !out_free;
  assign issue    = (state_r == ST_SCAN) && (idx_r < CW'(ROOMS)) && !stall;
  assign eval     = (state_r == ST_SCAN) && pend_r && !stall;

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    pidx_nxt     = pidx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    held_v_nxt   = held_v_r;
    held_nxt     = held_r;
    out_load     = 1'b0;
    out_nxt      = out_r;
    in_ready     = 1'b0;
    rd_en        = 1'b0;
    ctl          = '0;
    wr_idx       = pidx_r;
    wr_rep       = res.cls;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt   = in_item;
          idx_nxt    = '0;
          pend_nxt   = 1'b0;
          hit_nxt    = 1'b0;
          free_nxt   = 1'b0;
          held_v_nxt = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (issue) begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[AW-1:0];
        end else if (!stall) begin
          pend_nxt = 1'b0;
        end

        if (eval) begin
          if (refresh) begin
            if (slot_v) begin
              if (res.lost) begin
                ctl.clr_valid = 1'b1;
              end
              if (res.changed) begin
                ctl.rep_we = 1'b1;
              end
              if (res.lost || res.changed) begin
                if (held_v_r) begin
                  out_load = 1'b1;
                  out_nxt  = held_r;
                end
                held_v_nxt          = 1'b1;
                held_nxt            = '0;
                held_nxt.has_room   = 1'b1;
                held_nxt.room_addr  = rd_addr;
                held_nxt.strength   = res.cls[1:0];
              end
            end
          end else begin
            if (slot_v && res.addr_match && !hit_r) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = pidx_r;
            end
            if (!slot_v && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = pidx_r;
            end
          end
        end

        if ((idx_r == CW'(ROOMS)) && !stall) begin
          state_nxt = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_nxt   = '0;
          state_nxt = ST_IDLE;
          if (refresh) begin
            if (held_v_r) begin
              out_nxt            = held_r;
              out_nxt.any_update = 1'b1;
            end
          end else begin
            out_nxt.accepted = hit_r || free_r;
            wr_rep           = CODE_UNKNOWN;
            if (hit_r) begin
              wr_idx      = hit_idx_r;
              ctl.time_we = 1'b1;
            end else if (free_r) begin
              wr_idx        = free_idx_r;
              ctl.addr_we   = 1'b1;
              ctl.time_we   = 1'b1;
              ctl.rep_we    = 1'b1;
              ctl.set_valid = 1'b1;
            end
          end
          out_nxt.last = 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      interval_r  <= 8'd1;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        interval_r <= cfg_beacon_interval;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    pidx_r     <= pidx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    held_r     <= held_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign cfg_ready = 1'b1;

endmodule

@@ design/bpat_checker.sv @@
module bpat_checker import bpat_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result item changed or vanished");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block took a second item while the first was in work");

  a_not_last_is_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> out_item.has_room && !out_item.any_update)
    else $error("non-final result does not report a room");

  a_update_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.any_update |-> out_item.last && out_item.has_room)
    else $error("any_update outside the final room report");

  a_room_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.has_room |-> !out_item.accepted)
    else $error("room report flagged as accepted beacon");

endmodule

bind beacon_presence_aging_table_core bpat_checker u_bpat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
